>>> hdl/exlx_pkg.sv
// Shared types, character constants and classification for the expression lexer.
package exlx_pkg;

  localparam int unsigned FieldWidth = 16;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);

  localparam logic [7:0] CharDot    = 8'h2E;
  localparam logic [7:0] CharRParen = 8'h29;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharMinus  = 8'h2D;

  typedef enum logic [1:0] {
    KIND_LIT   = 2'd0,
    KIND_BIN   = 2'd1,
    KIND_UNARY = 2'd2,
    KIND_BAD   = 2'd3
  } token_kind_e;

  typedef enum logic [1:0] {
    CLS_SPACE  = 2'd0,
    CLS_NUMBER = 2'd1,
    CLS_OPER   = 2'd2,
    CLS_OTHER  = 2'd3
  } char_class_e;

  // One queue entry: the tokens caused by one input item, number first.
  typedef struct packed {
    logic                   has_num;
    token_kind_e            num_kind;
    logic [FieldWidth-1:0]  num_start;
    logic [FieldWidth-1:0]  num_length;
    logic                   has_chr;
    token_kind_e            chr_kind;
    logic [7:0]             chr_code;
    logic [FieldWidth-1:0]  chr_pos;
  } token_entry_t;

  function automatic char_class_e classify(input logic [7:0] c);
    char_class_e cls;
    case (c) inside
      8'h20, [8'h09:8'h0D]:                          cls = CLS_SPACE;
      [8'h30:8'h39], 8'h2E:                          cls = CLS_NUMBER;
      8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h78, 8'h28, 8'h29, 8'h5E: cls = CLS_OPER;
      default:                                       cls = CLS_OTHER;
    endcase
    return cls;
  endfunction

endpackage

>>> hdl/exlx_front.sv
// Front end: accept characters, track the number run and build token entries.
module exlx_front #(
  parameter int unsigned PositionWidth = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic                  cmd_i,
  input  logic [7:0]            char_code_i,
  input  logic                  full_i,
  output logic                  push_o,
  output exlx_pkg::token_entry_t entry_o
);

  localparam int unsigned ExtWidth =
      (PositionWidth > exlx_pkg::FieldWidth) ? PositionWidth : exlx_pkg::FieldWidth;
  localparam logic [PositionWidth-1:0] PosMax = {PositionWidth{1'b1}};

  function automatic logic [exlx_pkg::FieldWidth-1:0] to_field(
      input logic [PositionWidth-1:0] v);
    logic [ExtWidth-1:0] e;
    e = ExtWidth'(v);
    return e[exlx_pkg::FieldWidth-1:0];
  endfunction

  logic                     in_number_q, in_number_d;
  logic [1:0]               dot_count_q, dot_count_d;
  logic [PositionWidth-1:0] number_start_q, number_start_d;
  logic [PositionWidth-1:0] number_length_q, number_length_d;
  logic [PositionWidth-1:0] char_position_q, char_position_d;
  logic                     unary_allowed_q, unary_allowed_d;

  logic                     accept;
  logic                     unary_now;
  exlx_pkg::char_class_e    cls;
  exlx_pkg::token_entry_t   entry;

  assign accept = valid_i && !full_i;
  assign cls    = exlx_pkg::classify(char_code_i);

  always_comb begin
    in_number_d     = in_number_q;
    dot_count_d     = dot_count_q;
    number_start_d  = number_start_q;
    number_length_d = number_length_q;
    char_position_d = char_position_q;
    unary_allowed_d = unary_allowed_q;
    unary_now       = unary_allowed_q;

    entry.has_num    = 1'b0;
    entry.num_kind   = (dot_count_q >= 2'd2) ? exlx_pkg::KIND_BAD : exlx_pkg::KIND_LIT;
    entry.num_start  = to_field(number_start_q);
    entry.num_length = to_field(number_length_q);
    entry.has_chr    = 1'b0;
    entry.chr_kind   = exlx_pkg::KIND_BAD;
    entry.chr_code   = char_code_i;
    entry.chr_pos    = to_field(char_position_q);

    if (cmd_i) begin
      // End of text: flush any pending number, then back to reset values.
      entry.has_num   = in_number_q;
      in_number_d     = 1'b0;
      dot_count_d     = 2'd0;
      number_start_d  = '0;
      number_length_d = '0;
      char_position_d = '0;
      unary_allowed_d = 1'b1;
    end else begin
      if (char_position_q != PosMax) begin
        char_position_d = char_position_q + 1'b1;
      end
      if (in_number_q && cls == exlx_pkg::CLS_NUMBER) begin
        // Extend the run.
        if (char_code_i == exlx_pkg::CharDot && dot_count_q < 2'd2) begin
          dot_count_d = dot_count_q + 2'd1;
        end
        if (number_length_q != PosMax) begin
          number_length_d = number_length_q + 1'b1;
        end
      end else begin
        if (in_number_q) begin
          entry.has_num   = 1'b1;
          in_number_d     = 1'b0;
          unary_allowed_d = 1'b0;
          unary_now       = 1'b0;
        end
        case (cls)
          exlx_pkg::CLS_SPACE: begin
          end
          exlx_pkg::CLS_NUMBER: begin
            in_number_d     = 1'b1;
            number_start_d  = char_position_q;
            number_length_d = PositionWidth'(1);
            dot_count_d     = (char_code_i == exlx_pkg::CharDot) ? 2'd1 : 2'd0;
          end
          exlx_pkg::CLS_OPER: begin
            entry.has_chr   = 1'b1;
            entry.chr_kind  = (unary_now && (char_code_i == exlx_pkg::CharPlus ||
                                             char_code_i == exlx_pkg::CharMinus))
                              ? exlx_pkg::KIND_UNARY : exlx_pkg::KIND_BIN;
            unary_allowed_d = (char_code_i != exlx_pkg::CharRParen);
          end
          default: begin
            entry.has_chr   = 1'b1;
            entry.chr_kind  = exlx_pkg::KIND_BAD;
            unary_allowed_d = 1'b0;
          end
        endcase
      end
    end
  end

  assign push_o  = accept && (entry.has_num || entry.has_chr);
  assign entry_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_number_q     <= 1'b0;
      dot_count_q     <= 2'd0;
      number_start_q  <= '0;
      number_length_q <= '0;
      char_position_q <= '0;
      unary_allowed_q <= 1'b1;
    end else if (accept) begin
      in_number_q     <= in_number_d;
      dot_count_q     <= dot_count_d;
      number_start_q  <= number_start_d;
      number_length_q <= number_length_d;
      char_position_q <= char_position_d;
      unary_allowed_q <= unary_allowed_d;
    end
  end

endmodule

>>> hdl/exlx_queue.sv
// Small register queue of token entries between front and back end.
module exlx_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  exlx_pkg::token_entry_t wdata_i,
  input  logic                   pop_i,
  output exlx_pkg::token_entry_t rdata_o,
  output logic                   full_o,
  output logic                   empty_o
);

  localparam int unsigned PtrW = exlx_pkg::QueuePtrWidth;

  exlx_pkg::token_entry_t slots_q [exlx_pkg::QueueDepth];
  logic [PtrW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]          count_q;

  assign full_o  = (count_q == (PtrW+1)'(exlx_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign rdata_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> hdl/exlx_back.sv
// Back end: split queue entries into single token beats in an output register.
module exlx_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  exlx_pkg::token_entry_t entry_i,
  input  logic                   empty_i,
  output logic                   pop_o,
  input  logic                   stall_i,
  output logic                   valid_o,
  output logic [1:0]             token_kind_o,
  output logic [7:0]             token_char_o,
  output logic [15:0]            start_position_o,
  output logic [15:0]            token_length_o,
  output logic                   last_of_run_o
);

  logic        valid_q, valid_d;
  logic        phase_q, phase_d;
  logic        load;
  logic        take_num;
  logic [1:0]  kind_q;
  logic [7:0]  char_q;
  logic [15:0] start_q;
  logic [15:0] length_q;
  logic        last_q;

  assign load     = (!valid_q || !stall_i) && !empty_i;
  assign take_num = !phase_q && entry_i.has_num;
  assign pop_o    = load && !(take_num && entry_i.has_chr);

  always_comb begin
    phase_d = phase_q;
    valid_d = valid_q && stall_i;
    if (load) begin
      valid_d = 1'b1;
      phase_d = take_num && entry_i.has_chr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (take_num) begin
        kind_q   <= entry_i.num_kind;
        char_q   <= 8'd0;
        start_q  <= entry_i.num_start;
        length_q <= entry_i.num_length;
        last_q   <= !entry_i.has_chr;
      end else begin
        kind_q   <= entry_i.chr_kind;
        char_q   <= entry_i.chr_code;
        start_q  <= entry_i.chr_pos;
        length_q <= 16'd1;
        last_q   <= 1'b1;
      end
    end
  end

  assign valid_o          = valid_q;
  assign token_kind_o     = kind_q;
  assign token_char_o     = char_q;
  assign start_position_o = start_q;
  assign token_length_o   = length_q;
  assign last_of_run_o    = last_q;

endmodule

>>> hdl/expression_lexer.sv
// Top level of the expression lexer: front end, token queue and output back end.
//
// The lexer takes one character beat per cycle (cmd_i = 0) or an end-of-text
// beat (cmd_i = 1) and emits literal, operator and invalid tokens with their
// start position and length. Whitespace produces nothing; a run of digits and
// dots is reported as one token when the first character after it, or end of
// text, arrives. An operator or invalid character there yields two tokens,
// the number first, and last_of_run_o marks the final token of each input
// beat. Input is taken every cycle while the four-entry token queue has room,
// and each accepted character updates the lexer state. The output side
// delivers one token per cycle from its own register while out_stall_i is low,
// so an item with two tokens is delivered as two beats and the queue absorbs
// the difference. A beat's tokens pass from the front end into a queue entry
// and from there into the output register. Positions and lengths saturate at
// 2^POSITION_WIDTH - 1 and are reported in their low 16 bits. End of text
// returns all state to its reset values.
module expression_lexer #(
  parameter int unsigned POSITION_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  token_kind_o,
  output logic [7:0]  token_char_o,
  output logic [15:0] start_position_o,
  output logic [15:0] token_length_o,
  output logic        last_of_run_o
);

  logic                   push;
  logic                   pop;
  logic                   full;
  logic                   empty;
  exlx_pkg::token_entry_t wr_entry;
  exlx_pkg::token_entry_t rd_entry;

  // Hold input while the queue has no free entry.
  assign in_stall_o = full;

  exlx_front #(
    .PositionWidth(POSITION_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_i),
    .cmd_i      (cmd_i),
    .char_code_i(char_code_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (wr_entry)
  );

  // Decouple classification from token delivery.
  exlx_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(wr_entry),
    .pop_i  (pop),
    .rdata_o(rd_entry),
    .full_o (full),
    .empty_o(empty)
  );

  exlx_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .entry_i         (rd_entry),
    .empty_i         (empty),
    .pop_o           (pop),
    .stall_i         (out_stall_i),
    .valid_o         (out_valid_o),
    .token_kind_o    (token_kind_o),
    .token_char_o    (token_char_o),
    .start_position_o(start_position_o),
    .token_length_o  (token_length_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

>>> bench/tb_expression_lexer.sv
// Self-checking testbench for the expression lexer: directed table and random expressions.
`timescale 1ns / 1ps

module tb_expression_lexer;

  // Beat commands on cmd_i.
  localparam bit CmdChar = 1'b0;
  localparam bit CmdEnd  = 1'b1;

  localparam int unsigned PosWidth = 16;
  localparam logic [PosWidth-1:0] PosMax = '1;

  localparam int RandomBeats   = 1823;
  localparam int HoldCycles    = 400;    // long receiver hold-off, fills the token queue
  localparam int SettleCycles  = 10;     // settle time after the last predicted token is out
  localparam int WatchdogLimit = 4000;   // cycles with no beat on either side
  localparam int ShownFailures = 10;

  localparam logic [7:0] OpChars [8] = '{"+", "-", "*", "/", "x", "(", ")", "^"};
  localparam logic [7:0] SpaceChars [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

  // One output token as it appears on the result ports.
  typedef struct packed {
    exlx_pkg::token_kind_e kind;
    logic [7:0]            chr;
    logic [PosWidth-1:0]   start;
    logic [PosWidth-1:0]   len;
    logic                  run_end;
  } token_t;

  localparam token_t NoToken = '0;

  // Directed stimulus: one beat per row. Rows with typed set carry the one token
  // that the beat must produce; all others are left to the predictor.
  typedef struct packed {
    bit         cmd;
    logic [7:0] chr;
    bit         typed;
    token_t     tok;
  } dir_row_t;

  localparam int DirRows = 27;
  localparam dir_row_t DirTable [DirRows] = '{
    // leading sign right after reset is unary, and so is a sign after it
    '{CmdChar, exlx_pkg::CharMinus, 1'b1,
      '{exlx_pkg::KIND_UNARY, exlx_pkg::CharMinus, 16'd0, 16'd1, 1'b1}},
    '{CmdChar, exlx_pkg::CharPlus,  1'b1,
      '{exlx_pkg::KIND_UNARY, exlx_pkg::CharPlus,  16'd1, 16'd1, 1'b1}},
    // "1.5)" : literal closed by ')', two tokens on one beat
    '{CmdChar, "1",                  1'b0, NoToken},
    '{CmdChar, exlx_pkg::CharDot,    1'b0, NoToken},
    '{CmdChar, "5",                  1'b0, NoToken},
    '{CmdChar, exlx_pkg::CharRParen, 1'b0, NoToken},
    // whitespace keeps the no-unary state after ')'
    '{CmdChar, " ",                  1'b0, NoToken},
    '{CmdChar, exlx_pkg::CharMinus,  1'b1,
      '{exlx_pkg::KIND_BIN, exlx_pkg::CharMinus, 16'd7, 16'd1, 1'b1}},
    '{CmdChar, "(",                  1'b1, '{exlx_pkg::KIND_BIN, "(", 16'd8, 16'd1, 1'b1}},
    '{CmdChar, 8'h09,                1'b0, NoToken},
    '{CmdChar, exlx_pkg::CharPlus,   1'b1,
      '{exlx_pkg::KIND_UNARY, exlx_pkg::CharPlus, 16'd10, 16'd1, 1'b1}},
    // "...0*" : dot count saturates, invalid number then operator
    '{CmdChar, exlx_pkg::CharDot,    1'b0, NoToken},
    '{CmdChar, exlx_pkg::CharDot,    1'b0, NoToken},
    '{CmdChar, exlx_pkg::CharDot,    1'b0, NoToken},
    '{CmdChar, "0",                  1'b0, NoToken},
    '{CmdChar, "*",                  1'b0, NoToken},
    // byte 0 and byte 255 are invalid; a sign after an invalid token is binary
    '{CmdChar, 8'h00,                1'b1,
      '{exlx_pkg::KIND_BAD, 8'h00, 16'd16, 16'd1, 1'b1}},
    '{CmdChar, exlx_pkg::CharMinus,  1'b1,
      '{exlx_pkg::KIND_BIN, exlx_pkg::CharMinus, 16'd17, 16'd1, 1'b1}},
    '{CmdChar, 8'hFF,                1'b1,
      '{exlx_pkg::KIND_BAD, 8'hFF, 16'd18, 16'd1, 1'b1}},
    '{CmdChar, "/",                  1'b1, '{exlx_pkg::KIND_BIN, "/", 16'd19, 16'd1, 1'b1}},
    '{CmdChar, "x",                  1'b1, '{exlx_pkg::KIND_BIN, "x", 16'd20, 16'd1, 1'b1}},
    '{CmdChar, "^",                  1'b1, '{exlx_pkg::KIND_BIN, "^", 16'd21, 16'd1, 1'b1}},
    // end of text flushes the pending literal, a second one produces nothing
    '{CmdChar, "9",                  1'b0, NoToken},
    '{CmdEnd,  8'h5A,                1'b1,
      '{exlx_pkg::KIND_LIT, 8'h00, 16'd22, 16'd1, 1'b1}},
    '{CmdEnd,  8'hA5,                1'b0, NoToken},
    // state is back to reset: position 0, sign unary again
    '{CmdChar, exlx_pkg::CharPlus,   1'b1,
      '{exlx_pkg::KIND_UNARY, exlx_pkg::CharPlus, 16'd0, 16'd1, 1'b1}},
    '{CmdEnd,  8'h00,                1'b0, NoToken}
  };

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        cmd_i         = CmdChar;
  logic [7:0]  char_code_i   = 8'h00;
  logic        out_stall_i   = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  token_kind_o;
  logic [7:0]  token_char_o;
  logic [15:0] start_position_o;
  logic [15:0] token_length_o;
  logic        last_of_run_o;

  expression_lexer i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .char_code_i      (char_code_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .token_kind_o     (token_kind_o),
    .token_char_o     (token_char_o),
    .start_position_o (start_position_o),
    .token_length_o   (token_length_o),
    .last_of_run_o    (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Tokens predicted for accepted beats, oldest first.
  token_t tokens_due [$];

  int beats_sent     = 0;
  int tokens_checked = 0;
  int fail_count     = 0;
  int burst_left     = 0;
  int gap_max        = 3;
  bit hold_req       = 1'b0;

  // Lexer state as the predictor tracks it.
  bit                  lx_in_number;
  logic [1:0]          lx_dots;
  logic [PosWidth-1:0] lx_num_start;
  logic [PosWidth-1:0] lx_num_len;
  logic [PosWidth-1:0] lx_pos;
  bit                  lx_unary_ok;

  function automatic void lex_restart();
    lx_in_number = 1'b0;
    lx_dots      = 2'd0;
    lx_num_start = '0;
    lx_num_len   = '0;
    lx_pos       = '0;
    lx_unary_ok  = 1'b1;
  endfunction

  function automatic exlx_pkg::char_class_e lexeme_class(input logic [7:0] c);
    if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) return exlx_pkg::CLS_SPACE;
    if ((c >= "0" && c <= "9") || c == exlx_pkg::CharDot) return exlx_pkg::CLS_NUMBER;
    foreach (OpChars[i]) if (c == OpChars[i]) return exlx_pkg::CLS_OPER;
    return exlx_pkg::CLS_OTHER;
  endfunction

  // Close the pending number run; more than one dot makes it invalid.
  function automatic token_t close_number();
    token_t t;
    t.kind    = (lx_dots >= 2'd2) ? exlx_pkg::KIND_BAD : exlx_pkg::KIND_LIT;
    t.chr     = 8'h00;
    t.start   = lx_num_start;
    t.len     = lx_num_len;
    t.run_end = 1'b0;
    lx_in_number = 1'b0;
    lx_unary_ok  = 1'b0;
    return t;
  endfunction

  // Advance the predicted state by one accepted beat and queue its tokens,
  // number token first, with run_end on the last one.
  function automatic void lex_predict(input bit cmd, input logic [7:0] c);
    token_t              found [2];
    int                  n;
    logic [PosWidth-1:0] here;
    n = 0;
    if (cmd == CmdEnd) begin
      if (lx_in_number) begin
        found[n] = close_number();
        n++;
      end
      lex_restart();
    end else begin
      here = lx_pos;
      if (lx_pos != PosMax) lx_pos++;
      if (lx_in_number && lexeme_class(c) == exlx_pkg::CLS_NUMBER) begin
        // extend the run: dots saturate at two, length at the maximum
        if (c == exlx_pkg::CharDot && lx_dots < 2'd2) lx_dots++;
        if (lx_num_len != PosMax) lx_num_len++;
      end else begin
        if (lx_in_number) begin
          found[n] = close_number();
          n++;
        end
        case (lexeme_class(c))
          exlx_pkg::CLS_SPACE: begin
          end
          exlx_pkg::CLS_NUMBER: begin
            lx_in_number = 1'b1;
            lx_num_start = here;
            lx_num_len   = PosWidth'(1);
            lx_dots      = (c == exlx_pkg::CharDot) ? 2'd1 : 2'd0;
          end
          exlx_pkg::CLS_OPER: begin
            found[n].kind = ((c == exlx_pkg::CharPlus || c == exlx_pkg::CharMinus) &&
                             lx_unary_ok) ? exlx_pkg::KIND_UNARY : exlx_pkg::KIND_BIN;
            found[n].chr     = c;
            found[n].start   = here;
            found[n].len     = PosWidth'(1);
            found[n].run_end = 1'b0;
            n++;
            lx_unary_ok = (c != exlx_pkg::CharRParen);
          end
          default: begin
            found[n] = '{exlx_pkg::KIND_BAD, c, here, 16'd1, 1'b0};
            n++;
            lx_unary_ok = 1'b0;
          end
        endcase
      end
    end
    for (int i = 0; i < n; i++) begin
      found[i].run_end = (i == n - 1);
      tokens_due.push_back(found[i]);
    end
  endfunction

  // Offer one beat and hold it until accepted. Bursts of random length are
  // separated by random gaps with valid low; a gap limit of zero idles never.
  task automatic send_beat(input bit cmd, input logic [7:0] c, input bit typed,
                           input token_t typed_tok);
    int gap;
    int due_before;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    char_code_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    due_before = tokens_due.size();
    lex_predict(cmd, c);
    if (typed) begin
      // the table row states the token outright: replace the prediction
      while (tokens_due.size() > due_before) void'(tokens_due.pop_back());
      tokens_due.push_back(typed_tok);
    end
    beats_sent++;
  endtask

  // Drop valid and wait until every predicted token has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic void note_failure(input string what, input token_t want,
                                       input token_t got);
    fail_count++;
    if (fail_count <= ShownFailures)
      $display({"%0t: %s: want kind=%0d char=%02h start=%0d len=%0d last=%0b,",
                " got kind=%0d char=%02h start=%0d len=%0d last=%0b"},
               $realtime, what, want.kind, want.chr, want.start, want.len, want.run_end,
               got.kind, got.chr, got.start, got.len, got.run_end);
  endfunction

  // Receiver: check each accepted token against the oldest prediction, then
  // pick the next stall value. A hold-off request from the stimulus raises stall
  // and keeps it high until a countdown from HoldCycles, kept here, runs out;
  // otherwise a stall mode is kept for a random stretch (none, light, heavy, periodic).
  int rx_mode   = 0;
  int rx_left   = 0;
  int hold_left = 0;
  int rx_tick   = 0;

  always @(posedge clk_i) begin
    token_t got;
    token_t want;
    if (out_valid_o && !out_stall_i) begin
      got = '{exlx_pkg::token_kind_e'(token_kind_o), token_char_o, start_position_o,
              token_length_o, last_of_run_o};
      if (tokens_due.size() == 0) begin
        note_failure("token with nothing expected", NoToken, got);
      end else begin
        want = tokens_due.pop_front();
        tokens_checked++;
        if (got !== want) note_failure("token mismatch", want, got);
      end
    end
    rx_tick++;
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= rx_tick[1];
      endcase
    end
  end

  // Watchdog: end the run when neither side has moved a beat for too long.
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no beat for %0d cycles", $realtime, WatchdogLimit);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int  target;
    int  pick;
    int  dot_pct;
    bit  held;
    held = 1'b0;
    lex_restart();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, then let everything drain before the random part.
    for (int i = 0; i < DirRows; i++)
      send_beat(DirTable[i].cmd, DirTable[i].chr, DirTable[i].typed, DirTable[i].tok);
    wait_drained();

    // Random part: mostly expression-like runs of numbers, operators and spaces closed by end of text,
    // mixed with bursts of raw noise bytes and stray end-of-text beats.
    target = DirRows + RandomBeats;
    while (beats_sent < target) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_max = 0;
          1:       gap_max = 3;
          default: gap_max = 12;
        endcase
      end
      if (!held && beats_sent > DirRows + RandomBeats / 2) begin
        // hold the receiver off while offering beats back to back
        hold_req = 1'b1;
        gap_max  = 0;
        held     = 1'b1;
      end
      if ($urandom_range(0, 9) < 2) begin
        repeat ($urandom_range(1, 6))
          send_beat(($urandom_range(0, 9) == 0) ? CmdEnd : CmdChar,
                    8'($urandom_range(0, 255)), 1'b0, NoToken);
      end else begin
        case ($urandom_range(0, 9))
          0, 1:    dot_pct = 40;
          2, 3, 4: dot_pct = 12;
          default: dot_pct = 0;
        endcase
        repeat ($urandom_range(1, 10)) begin
          pick = $urandom_range(0, 99);
          if (pick < 10) begin
            send_beat(CmdChar, SpaceChars[$urandom_range(0, 5)], 1'b0, NoToken);
          end else if (pick < 50) begin
            repeat ($urandom_range(1, 6))
              send_beat(CmdChar, ($urandom_range(0, 99) < dot_pct) ? exlx_pkg::CharDot :
                        8'("0" + $urandom_range(0, 9)), 1'b0, NoToken);
          end else if (pick < 60) begin
            send_beat(CmdChar, $urandom_range(0, 1) ? exlx_pkg::CharPlus :
                      exlx_pkg::CharMinus, 1'b0, NoToken);
          end else begin
            send_beat(CmdChar, OpChars[$urandom_range(0, 7)], 1'b0, NoToken);
          end
        end
        if ($urandom_range(0, 99) < 85)
          send_beat(CmdEnd, 8'($urandom_range(0, 255)), 1'b0, NoToken);
      end
      if ($urandom_range(0, 39) == 0) wait_drained();
    end
    wait_drained();

    if (tokens_due.size() != 0) begin
      fail_count++;
      $display("%0d predicted tokens never arrived", tokens_due.size());
    end
    $display("Ran %0d beats: directed table, then random expressions with noise bytes,",
             beats_sent);
    $display("bursty input and a long output hold-off; %0d tokens checked, %0d failures",
             tokens_checked, fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> expression_lexer.f
hdl/exlx_pkg.sv
hdl/exlx_front.sv
hdl/exlx_queue.sv
hdl/exlx_back.sv
hdl/expression_lexer.sv
bench/tb_expression_lexer.sv
